### rtl/swmq_pkg.sv
// Shared types and constants for the priority stack/queue unit.
// Used by swmq_cell, the top level and the port checker. No dependencies.
package swmq_pkg;

  // Number of entry cells and derived widths
  localparam int DEPTH  = 16;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 8;
  localparam int PRIO_W = 16;

  // Operation codes
  localparam logic [1:0] OP_INSERT        = 2'd0;
  localparam logic [1:0] OP_REMOVE_MAX    = 2'd1;
  localparam logic [1:0] OP_REMOVE_NEWEST = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Input transfer payload
  typedef struct packed {
    logic [1:0]        operation;
    logic [DATA_W-1:0] data_in;
    logic [PRIO_W-1:0] priority_in;
  } in_t;

  // Output transfer payload
  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic [1:0]        status;
  } out_t;

  // One stored entry
  typedef struct packed {
    logic [DATA_W-1:0] byte_val;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // Candidate carried down the chain during a removal search
  typedef struct packed {
    logic              ok;
    logic [IDX_W-1:0]  pos;
    logic [DATA_W-1:0] byte_val;
    logic [PRIO_W-1:0] prio;
  } wave_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic              newest;
    logic [IDX_W-1:0]  pos;
    logic [CNT_W-1:0]  count;
    entry_t            new_entry;
  } ctl_t;

endpackage

### rtl/swmq_cell.sv
// One storage cell of the entry chain: holds one entry and one search stage.
// Depends on swmq_pkg.
module swmq_cell (
  input  logic                     clk,
  input  logic [swmq_pkg::IDX_W-1:0] idx,
  input  swmq_pkg::ctl_t           ctl,
  input  swmq_pkg::entry_t         up_entry,
  input  swmq_pkg::wave_t          wave_in,
  output swmq_pkg::entry_t         entry,
  output swmq_pkg::wave_t          wave_pick,
  output swmq_pkg::wave_t          wave_q
);
  import swmq_pkg::*;

  logic [CNT_W-1:0] idx_c;
  logic             occupied;
  logic             take;

  assign idx_c    = CNT_W'(idx);
  assign occupied = idx_c < ctl.count;

  // Search stage: newest mode keeps the last occupied cell, max mode keeps
  // the first cell of the greatest priority (strict compare keeps the oldest)
  always_comb begin
    take = occupied && (!wave_in.ok || ctl.newest || (entry.prio > wave_in.prio));
    if (take) begin
      wave_pick.ok       = 1'b1;
      wave_pick.pos      = idx;
      wave_pick.byte_val = entry.byte_val;
      wave_pick.prio     = entry.prio;
    end else begin
      wave_pick = wave_in;
    end
  end

  // Hand the candidate to the next cell every cycle
  always_ff @(posedge clk) begin
    wave_q <= wave_pick;
  end

  // Storage: load at the free slot, or close the gap left by a removal
  always_ff @(posedge clk) begin
    if (ctl.ins && (idx_c == ctl.count)) begin
      entry <= ctl.new_entry;
    end else if (ctl.rem && (idx >= ctl.pos) && ((idx_c + CNT_W'(1)) < ctl.count)) begin
      entry <= up_entry;
    end
  end

endmodule

### rtl/stack_with_max_extract_queue_unit.sv
// Top level of the priority stack/queue unit: sequencer plus chain of cells.
// Depends on swmq_pkg and swmq_cell.
//
//   channel | signals                          | payload
//   --------+----------------------------------+-------------------------------
//   in      | in_valid / in_ready / in_data    | operation, data_in, priority_in
//   out     | out_valid / out_ready / out_data | data_out, status
//
// Insert, refused insert, removal from empty and unknown codes go straight to
// the done state. Removals from a non-empty store pass first through the scan
// state, where the candidate search steps one cell per cycle down the chain.
// One item is in work at a time; a new item is taken while a result waits.
// A stalled output holds the finished item in its done state.
// rst is synchronous; it empties the store (stored entries are not cleared).
module stack_with_max_extract_queue_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  swmq_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output swmq_pkg::out_t  out_data
);
  import swmq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  scan_cnt;
  logic              newest;
  out_t              res;
  logic              in_fire;
  logic              full;
  logic              scan_end;
  ctl_t              ctl;

  entry_t            entries [DEPTH];
  wave_t             picks   [DEPTH];
  wave_t             waves   [DEPTH];

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign full     = (count == CNT_W'(DEPTH));
  assign scan_end = (state == S_SCAN) && (scan_cnt == '0);

  // Broadcast control to the cells
  always_comb begin
    ctl.ins       = in_fire && (in_data.operation == OP_INSERT) && !full;
    ctl.rem       = scan_end;
    ctl.newest    = newest;
    ctl.pos       = picks[DEPTH-1].pos;
    ctl.count     = count;
    ctl.new_entry = '{byte_val: in_data.data_in, prio: in_data.priority_in};
  end

  // Chain of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t up_entry;
    wave_t  wave_in;
    if (i == DEPTH - 1) begin : g_last
      assign up_entry = '0;
    end else begin : g_mid
      assign up_entry = entries[i+1];
    end
    if (i == 0) begin : g_first
      assign wave_in = '0;
    end else begin : g_rest
      assign wave_in = waves[i-1];
    end
    swmq_cell u_cell (
      .clk       (clk),
      .idx       (IDX_W'(i)),
      .ctl       (ctl),
      .up_entry  (up_entry),
      .wave_in   (wave_in),
      .entry     (entries[i]),
      .wave_pick (picks[i]),
      .wave_q    (waves[i])
    );
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      scan_cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            unique case (in_data.operation)
              OP_INSERT: begin
                state <= S_DONE;
                if (full) begin
                  res <= '{data_out: '0, status: ST_FULL};
                end else begin
                  res   <= '{data_out: '0, status: ST_OK};
                  count <= count + CNT_W'(1);
                end
              end
              OP_REMOVE_MAX, OP_REMOVE_NEWEST: begin
                if (count == '0) begin
                  res   <= '{data_out: '0, status: ST_EMPTY};
                  state <= S_DONE;
                end else begin
                  res      <= '{data_out: '0, status: ST_OK};
                  newest   <= (in_data.operation == OP_REMOVE_NEWEST);
                  scan_cnt <= IDX_W'(DEPTH - 1);
                  state    <= S_SCAN;
                end
              end
              default: begin
                res   <= '{data_out: '0, status: ST_OK};
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          scan_cnt <= scan_cnt - IDX_W'(1);
          if (scan_end) begin
            res.data_out <= picks[DEPTH-1].byte_val;
            count        <= count - CNT_W'(1);
            state        <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!out_valid || out_ready)) begin
      out_data <= res;
    end
  end

endmodule

### rtl/swmq_checker.sv
// Port-level checker for the priority stack/queue unit, bound to the top.
// Depends on swmq_pkg and stack_with_max_extract_queue_unit.
module swmq_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input swmq_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input swmq_pkg::out_t out_data
);
  import swmq_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  // Status is one of the defined codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.status == ST_OK || out_data.status == ST_EMPTY ||
                   out_data.status == ST_FULL))
    else $error("undefined status code");

  // Failed operations return zero data
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |-> out_data.data_out == '0)
    else $error("nonzero data with failure status");

  // One item at a time: no transfer in the cycle after a transfer in
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  // A refused insert only follows an insert transfer
  a_full_cause: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.operation != OP_INSERT |=>
      ##1 !(out_valid && $rose(out_valid) && out_data.status == ST_FULL))
    else $error("full status for a non-insert");

endmodule

bind stack_with_max_extract_queue_unit swmq_checker u_swmq_checker (.*);
